### hdl/ekd_pkg.sv
// shared types, constants and key sequence table for the escape sequence key decoder
package ekd_pkg;

    localparam int KEY_TABLE_SIZE   = 39;
    localparam int NUM_KEYS_DEF     = 39;
    localparam int MAX_SEQUENCE_DEF = 7;
    localparam int QUEUE_DEPTH_DEF  = 2;

    localparam int CODE_W    = 11;
    localparam int KLEN_W    = 3;
    localparam int POS_W     = 5;

    localparam logic [7:0] ESC_BYTE   = 8'd27;
    localparam logic [7:0] ALT_M_BYTE = 8'd237;

    localparam logic [CODE_W-1:0] CODE_NONE  = 11'd0;
    localparam logic [CODE_W-1:0] CODE_ERROR = 11'd1038;
    localparam logic [CODE_W-1:0] CODE_ALT_M = 11'd1039;

    typedef struct packed {
        logic [7:0] key_byte;
        logic       is_esc;
        logic       is_ascii;
        logic       is_alt_m;
    } t_item;

    localparam logic [CODE_W-1:0] KEY_CODES [KEY_TABLE_SIZE] = '{
        11'd1000, 11'd1001, 11'd1002, 11'd1003, 11'd1004, 11'd1005, 11'd1006,
        11'd1007, 11'd1008, 11'd1009, 11'd1010, 11'd1011, 11'd1012, 11'd1013,
        11'd1014, 11'd1015, 11'd1016, 11'd1017, 11'd1018, 11'd1019, 11'd1020,
        11'd1021, 11'd1022, 11'd1023, 11'd1024, 11'd1025, 11'd1026, 11'd1028,
        11'd1030, 11'd1031, 11'd1032, 11'd1033, 11'd1034, 11'd1035, 11'd1036,
        11'd1027, 11'd1029, 11'd1039, 11'd1039
    };

    localparam logic [KLEN_W-1:0] KEY_LENS [KEY_TABLE_SIZE] = '{
        3'd3, 3'd3, 3'd3, 3'd3, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
        3'd4, 3'd4, 3'd4, 3'd4, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6,
        3'd4, 3'd4, 3'd3, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd3, 3'd3, 3'd2, 3'd2
    };

    // first byte of each sequence in the lowest bits
    localparam logic [63:0] KEY_SEQS [KEY_TABLE_SIZE] = '{
        64'h504F1B, 64'h514F1B, 64'h524F1B, 64'h534F1B,
        64'h7E35315B1B, 64'h7E37315B1B, 64'h7E38315B1B, 64'h7E39315B1B,
        64'h7E30325B1B, 64'h7E31325B1B, 64'h7E33325B1B, 64'h7E34325B1B,
        64'h504F1B1B, 64'h514F1B1B, 64'h524F1B1B, 64'h534F1B1B,
        64'h7E35315B1B1B, 64'h7E37315B1B1B, 64'h7E38315B1B1B, 64'h7E39315B1B1B,
        64'h7E30325B1B1B, 64'h7E31325B1B1B, 64'h7E33325B1B1B, 64'h7E34325B1B1B,
        64'h7E325B1B, 64'h7E335B1B, 64'h485B1B, 64'h465B1B,
        64'h7E355B1B, 64'h7E365B1B, 64'h5A5B1B, 64'h415B1B,
        64'h425B1B, 64'h435B1B, 64'h445B1B, 64'h484F1B,
        64'h464F1B, 64'h6D1B, 64'h4D1B
    };

    function automatic logic [7:0] key_seq_byte(input int idx, input logic [POS_W-1:0] pos);
        logic [7:0] b;
        b = 8'd0;
        if (pos < POS_W'(8)) begin
            b = KEY_SEQS[idx][pos[2:0]*8 +: 8];
        end
        return b;
    endfunction

endpackage

### hdl/ekd_queue.sv
// small register queue between the front and back parts
module ekd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_valid,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_wr_ready,
    output logic             o_rd_valid,
    output logic [WIDTH-1:0] o_rd_data,
    input  logic             i_rd_ready
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             push, pop;

    assign o_wr_ready = (r_count != CW'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CW'(1);
        end else if (pop && !push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

### hdl/ekd_front.sv
// input side: accepts keyboard bytes, classifies them and queues them
module ekd_front
    import ekd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // key_byte
    output logic       o_q_valid,
    output t_item      o_q_item,
    input  logic       i_q_ready
);

    t_item             item;
    logic [$bits(t_item)-1:0] rd_bits;

    always_comb begin
        item.key_byte = i_s_tdata;
        item.is_esc   = (i_s_tdata == ESC_BYTE);
        item.is_ascii = !i_s_tdata[7] && (i_s_tdata != ESC_BYTE);
        item.is_alt_m = (i_s_tdata == ALT_M_BYTE);
    end

    ekd_queue #(
        .WIDTH ($bits(t_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_s_tvalid),
        .i_wr_data  (item),
        .o_wr_ready (o_s_tready),
        .o_rd_valid (o_q_valid),
        .o_rd_data  (rd_bits),
        .i_rd_ready (i_q_ready)
    );

    assign o_q_item = t_item'(rd_bits);

endmodule

### hdl/ekd_back.sv
// output side: tracks the escape sequence against the key table and registers the key code
module ekd_back
    import ekd_pkg::*;
#(
    parameter int NUM_KEYS     = NUM_KEYS_DEF,
    parameter int MAX_SEQUENCE = MAX_SEQUENCE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_q_ready,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // key_code, zero padding
);

    localparam int ACTIVE = (NUM_KEYS < KEY_TABLE_SIZE) ? NUM_KEYS : KEY_TABLE_SIZE;
    localparam int LW     = $clog2(MAX_SEQUENCE + 1);
    localparam int CW     = (LW > KLEN_W) ? LW : KLEN_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SEQ  = 2'b10
    } t_state;

    t_state              r_state,   n_state;
    logic [LW-1:0]       r_len,     n_len;
    logic [ACTIVE-1:0]   r_dropped, n_dropped;
    logic [ACTIVE-1:0]   r_ok,      n_ok;
    logic                r_out_valid;
    logic [CODE_W-1:0]   r_out_code;
    logic [CODE_W-1:0]   code;
    logic [LW-1:0]       new_len;
    logic [ACTIVE-1:0]   eq;
    logic [ACTIVE-1:0]   hit;
    logic                pop;

    assign o_q_ready  = !r_out_valid || i_m_tready;
    assign pop        = i_q_valid && o_q_ready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(16 - CODE_W){1'b0}}, r_out_code};
    assign new_len    = r_len + LW'(1);

    always_comb begin
        for (int i = 0; i < ACTIVE; i++) begin
            eq[i]  = r_ok[i] && (i_q_item.key_byte == key_seq_byte(i, POS_W'(r_len)));
            hit[i] = !r_dropped[i] && eq[i] && (CW'(new_len) == CW'(KEY_LENS[i]));
        end
    end

    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_dropped = r_dropped;
        n_ok      = r_ok;
        code      = CODE_NONE;
        case (r_state)
            ST_IDLE: begin
                if (i_q_item.is_esc) begin
                    n_state   = ST_SEQ;
                    n_len     = LW'(1);
                    n_dropped = '0;
                    for (int i = 0; i < ACTIVE; i++) begin
                        n_ok[i] = (key_seq_byte(i, '0) == ESC_BYTE);
                    end
                end else if (i_q_item.is_ascii) begin
                    code = {{(CODE_W - 8){1'b0}}, i_q_item.key_byte};
                end else if (i_q_item.is_alt_m) begin
                    code = CODE_ALT_M;
                end
            end
            ST_SEQ: begin
                if (&r_dropped || (r_len >= LW'(MAX_SEQUENCE))) begin
                    code    = CODE_ERROR;
                    n_state = ST_IDLE;
                    n_len   = '0;
                end else if (|hit) begin
                    // lowest table entry wins
                    for (int i = ACTIVE - 1; i >= 0; i--) begin
                        if (hit[i]) begin
                            code = KEY_CODES[i];
                        end
                    end
                    n_state = ST_IDLE;
                    n_len   = '0;
                end else begin
                    n_len = new_len;
                    n_ok  = eq;
                    for (int i = 0; i < ACTIVE; i++) begin
                        if (CW'(new_len) >= CW'(KEY_LENS[i])) begin
                            n_dropped[i] = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_len   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_dropped   <= '0;
            r_ok        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_state   <= n_state;
                r_len     <= n_len;
                r_dropped <= n_dropped;
                r_ok      <= n_ok;
            end
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_code <= code;
        end
    end

endmodule

### hdl/escape_sequence_key_decoder.sv
// top level of the escape sequence key decoder
// One key code comes out for every keyboard byte, in order. The block takes a byte on
// every clock cycle while neither side stalls: the front part classifies it and writes
// it into a short queue in the same cycle, and the back part matches it against all
// table entries in parallel and registers the key code, so each byte passes the queue
// and then the output register. The queue and the output register let either side stall
// without losing a byte; with the output held the block takes up to QUEUE_DEPTH more bytes.
module escape_sequence_key_decoder
    import ekd_pkg::*;
#(
    parameter int NUM_KEYS     = NUM_KEYS_DEF,
    parameter int MAX_SEQUENCE = MAX_SEQUENCE_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // key_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // key_code [10:0], zero padding above
);

    logic  q_valid;
    logic  q_ready;
    t_item q_item;

    ekd_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_ready  (q_ready)
    );

    ekd_back #(
        .NUM_KEYS     (NUM_KEYS),
        .MAX_SEQUENCE (MAX_SEQUENCE)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_item   (q_item),
        .o_q_ready  (q_ready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

### bench/escape_sequence_key_decoder_tb.sv
// testbench for the escape sequence key decoder: byte stream in, key codes checked in order
`timescale 1ns / 1ps

module escape_sequence_key_decoder_tb;

    localparam int          MAX_SEQ      = 7;
    localparam int          RANDOM_ITEMS = 450;
    localparam logic [7:0]  ESC_KEY      = 8'd27;
    localparam logic [7:0]  ALT_M_KEY    = 8'd237;
    localparam logic [10:0] NO_KEY       = 11'd0;
    localparam logic [10:0] ERR_KEY      = 11'd1038;
    localparam logic [10:0] ALT_M_VAL    = 11'd1039;

    class key_decode_checker;
        string          key_seq[$];
        int unsigned    key_val[$];
        logic [10:0]    pending_codes[$];
        bit             in_seq;
        logic [7:0]     seq_bytes[MAX_SEQ];
        int             seq_len;
        bit [63:0]      dropped;
        int             errors;
        int             checked;
        int             fkeys;
        int             bad_seqs;

        function new();
            add_key(1000, "\033OP");   add_key(1001, "\033OQ");   add_key(1002, "\033OR");
            add_key(1003, "\033OS");   add_key(1004, "\033[15~"); add_key(1005, "\033[17~");
            add_key(1006, "\033[18~"); add_key(1007, "\033[19~"); add_key(1008, "\033[20~");
            add_key(1009, "\033[21~"); add_key(1010, "\033[23~"); add_key(1011, "\033[24~");
            add_key(1012, "\033\033OP");   add_key(1013, "\033\033OQ");
            add_key(1014, "\033\033OR");   add_key(1015, "\033\033OS");
            add_key(1016, "\033\033[15~"); add_key(1017, "\033\033[17~");
            add_key(1018, "\033\033[18~"); add_key(1019, "\033\033[19~");
            add_key(1020, "\033\033[20~"); add_key(1021, "\033\033[21~");
            add_key(1022, "\033\033[23~"); add_key(1023, "\033\033[24~");
            add_key(1024, "\033[2~");  add_key(1025, "\033[3~");  add_key(1026, "\033[H");
            add_key(1028, "\033[F");   add_key(1030, "\033[5~");  add_key(1031, "\033[6~");
            add_key(1032, "\033[Z");   add_key(1033, "\033[A");   add_key(1034, "\033[B");
            add_key(1035, "\033[C");   add_key(1036, "\033[D");   add_key(1027, "\033OH");
            add_key(1029, "\033OF");   add_key(1039, "\033m");    add_key(1039, "\033M");
            in_seq  = 1'b0;
            seq_len = 0;
            dropped = '0;
            errors  = 0;
            checked = 0;
            fkeys   = 0;
            bad_seqs = 0;
        endfunction

        function void add_key(int unsigned code, string s);
            key_val.push_back(code);
            key_seq.push_back(s);
        endfunction

        function logic [10:0] decode_key(logic [7:0] b);
            int  i;
            int  k;
            bit  live;
            bit  hit;
            if (!in_seq) begin
                if (b == ESC_KEY) begin
                    in_seq       = 1'b1;
                    seq_bytes[0] = b;
                    seq_len      = 1;
                    dropped      = '0;
                    return NO_KEY;
                end
                if (b <= 8'd127) return {3'b000, b};
                if (b == ALT_M_KEY) return ALT_M_VAL;
                return NO_KEY;
            end
            live = 1'b0;
            for (i = 0; i < key_seq.size(); i++)
                if (!dropped[i]) live = 1'b1;
            if (!live || seq_len >= MAX_SEQ) begin
                in_seq  = 1'b0;
                seq_len = 0;
                return ERR_KEY;
            end
            seq_bytes[seq_len] = b;
            seq_len++;
            for (i = 0; i < key_seq.size(); i++) begin
                if (dropped[i]) continue;
                hit = (key_seq[i].len() == seq_len);
                for (k = 0; hit && k < seq_len; k++)
                    if (seq_bytes[k] != 8'(key_seq[i].getc(k))) hit = 1'b0;
                if (hit) begin
                    in_seq  = 1'b0;
                    seq_len = 0;
                    return 11'(key_val[i]);
                end
                if (seq_len >= key_seq[i].len()) dropped[i] = 1'b1;
            end
            return NO_KEY;
        endfunction

        function void note_byte(logic [7:0] b);
            pending_codes.push_back(decode_key(b));
        endfunction

        task flag_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_code(logic [15:0] data);
            logic [10:0] want;
            if (pending_codes.size() == 0) begin
                flag_mismatch($sformatf("key code %0d with no item outstanding", data[10:0]));
                return;
            end
            want = pending_codes.pop_front();
            checked++;
            if (want == ERR_KEY) bad_seqs++;
            else if (want >= 11'd1000) fkeys++;
            if (data[10:0] != want)
                flag_mismatch($sformatf("key_code %0d, expected %0d (result %0d)",
                                        data[10:0], want, checked));
            if (data[15:11] != 5'd0)
                flag_mismatch($sformatf("padding bits %b not zero", data[15:11]));
        endtask

        function int pending();
            return pending_codes.size();
        endfunction
    endclass

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'd0;   // key_byte
    logic        m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [15:0] o_m_tdata;         // key_code [10:0], zero padding above

    key_decode_checker board = new();
    int                calm_left = 0;
    int                items_sent = 0;

    escape_sequence_key_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #1 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 20);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (calm_left > 0) begin
            gap = 0;
            calm_left--;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 29) == 0) calm_left = 20;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.note_byte(b);
        items_sent++;
    endtask

    // result side: compare every accepted key code
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && m_tready) board.check_code(o_m_tdata);
    end

    // result side ready: random stalls, one long hold-off to back up the block
    initial begin
        int  stall;
        bit  held;
        held = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = pick_gap();
            if (!held && board.checked >= 150) begin
                held  = 1'b1;
                stall = stall + 60;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0) repeat (40) @(posedge i_clk);
            else repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    initial begin
        logic [7:0] stim[$];
        string      s;
        int         kind;
        int         pick;
        int         cut;
        int         k;
        int         total;

        // idle bytes at the extremes, plain ascii, alt-m
        stim = '{8'd0, 8'd127, 8'd128, 8'd255, ALT_M_KEY, 8'd65};
        // short function key, then escape inside a sequence
        stim.push_back(ESC_KEY); stim.push_back("O"); stim.push_back("P");
        stim.push_back(ESC_KEY); stim.push_back(ESC_KEY); stim.push_back("[");
        stim.push_back("2"); stim.push_back("4"); stim.push_back("~");
        // two byte alt sequence
        stim.push_back(ESC_KEY); stim.push_back("M");
        // zero byte in a sequence, then run out of live entries
        stim.push_back(ESC_KEY); stim.push_back(8'd0); stim.push_back("x");
        stim.push_back("y"); stim.push_back("z"); stim.push_back(8'd1);
        stim.push_back(8'd2);
        total = stim.size() + RANDOM_ITEMS;

        while (stim.size() < total) begin
            kind = $urandom_range(0, 99);
            pick = $urandom_range(0, board.key_seq.size() - 1);
            s    = board.key_seq[pick];
            if (kind < 60) begin
                for (k = 0; k < s.len(); k++) stim.push_back(8'(s.getc(k)));
            end else if (kind < 75) begin
                cut = $urandom_range(1, s.len() - 1);
                for (k = 0; k < s.len(); k++)
                    stim.push_back(k == cut ? 8'($urandom_range(0, 255)) : 8'(s.getc(k)));
            end else if (kind < 85) begin
                cut = $urandom_range(1, s.len() - 1);
                for (k = 0; k < cut; k++) stim.push_back(8'(s.getc(k)));
            end else begin
                repeat ($urandom_range(1, 4)) stim.push_back(8'($urandom_range(0, 255)));
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim[k]) send_byte(stim[k]);
        s_tvalid <= 1'b0;

        while (board.pending() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("sent %0d keyboard bytes, checked %0d key codes", items_sent, board.checked);
        $display("%0d function or alt keys decoded, %0d broken sequences flagged",
                 board.fkeys, board.bad_seqs);
        if (board.errors == 0) begin
            $display("escape_sequence_key_decoder_tb OK");
        end else begin
            $display("escape_sequence_key_decoder_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #500000;
        $display("timeout with %0d key codes outstanding", board.pending());
        $display("escape_sequence_key_decoder_tb NOT OK");
        $finish;
    end

endmodule

### escape_sequence_key_decoder.f
hdl/ekd_pkg.sv
hdl/ekd_queue.sv
hdl/ekd_front.sv
hdl/ekd_back.sv
hdl/escape_sequence_key_decoder.sv
bench/escape_sequence_key_decoder_tb.sv
